/* rtl/lcfp_pkg.sv */
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types, opcodes and helper functions for the LSTM pointwise cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfp_pkg;

   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_LOAD    = 1'b1;

   // one bias entry: summed biases of the four gates
   typedef struct packed {
      logic signed [15:0] gi;
      logic signed [15:0] gf;
      logic signed [15:0] gc;
      logic signed [15:0] go;
   } bias_entry_type;

   // tanh(k/4) in Q0.16, k = 0..32
   function automatic logic [16:0] tanh_q16(input logic [5:0] k);
      logic [16:0] r;
      case (k)
         6'd0:  r = 17'd0;
         6'd1:  r = 17'd16051;
         6'd2:  r = 17'd30285;
         6'd3:  r = 17'd41625;
         6'd4:  r = 17'd49912;
         6'd5:  r = 17'd55593;
         6'd6:  r = 17'd59320;
         6'd7:  r = 17'd61694;
         6'd8:  r = 17'd63179;
         6'd9:  r = 17'd64096;
         6'd10: r = 17'd64659;
         6'd11: r = 17'd65003;
         6'd12: r = 17'd65212;
         6'd13: r = 17'd65339;
         6'd14: r = 17'd65417;
         6'd15: r = 17'd65464;
         6'd16: r = 17'd65492;
         6'd17: r = 17'd65509;
         6'd18: r = 17'd65520;
         6'd19: r = 17'd65526;
         6'd20: r = 17'd65530;
         6'd21: r = 17'd65532;
         6'd22: r = 17'd65534;
         6'd23: r = 17'd65535;
         6'd24: r = 17'd65535;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   // saturate a wide signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      logic signed [15:0] r;
      if (v > 34'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/lcfp_bias_mem.sv */
// ----------------------------------------------------------------------------
// lcfp_bias_mem
// Per-feature gate bias store, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfp_bias_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [AW-1:0]                 wr_addr,
   input  wire lcfp_pkg::bias_entry_type wr_data,
   input  wire                          rd_en,
   input  wire [AW-1:0]                 rd_addr,
   output lcfp_pkg::bias_entry_type     rd_data
);

   lcfp_pkg::bias_entry_type mem [DEPTH];
   lcfp_pkg::bias_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read sees writes from earlier edges only
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

/* rtl/lcfp_act.sv */
// ----------------------------------------------------------------------------
// lcfp_act
// Two-stage interpolated tanh / sigmoid: table lookup, then interpolate+round.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfp_act #(
   parameter int FRAC_BITS = 12,
   parameter bit SIGMOID   = 1'b0
) (
   input  wire               clock,
   input  wire               en_a,
   input  wire               en_b,
   input  wire signed [15:0] x,
   output logic signed [15:0] y
);

   localparam int SH  = SIGMOID ? FRAC_BITS - 1 : FRAC_BITS - 2;
   localparam int RSH = SIGMOID ? 17 - FRAC_BITS : 16 - FRAC_BITS;
   localparam logic [17:0] RND = 18'(1) << (RSH - 1);
   localparam logic [17:0] ONE = 18'h10000;

   logic [15:0]    mag;
   logic [15:0]    k;
   logic [16:0]    base, nxt;
   logic           neg_ff, sat_ff;
   logic [16:0]    base_ff;
   logic [15:0]    d_ff;
   logic [SH-1:0]  fr_ff;
   logic [SH+15:0] prod;
   logic [17:0]    t, sv, r;

   always_comb begin
      mag  = x[15] ? (~x + 16'd1) : x;   // most negative maps to 0x8000
      k    = mag >> SH;
      base = lcfp_pkg::tanh_q16(k[5:0]);
      nxt  = lcfp_pkg::tanh_q16(k[5:0] + 6'd1);
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         neg_ff  <= x[15];
         sat_ff  <= (k >= 16'd32);
         base_ff <= base;
         d_ff    <= 16'(nxt - base);
         fr_ff   <= mag[SH-1:0];
      end
   end

   always_comb begin
      prod = d_ff * fr_ff;
      t    = sat_ff ? ONE : (18'(base_ff) + 18'(prod >> SH));
      if (SIGMOID) begin
         sv = neg_ff ? (ONE - t) : (ONE + t);
      end else begin
         sv = t;
      end
      r = (sv + RND) >> RSH;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         y <= (!SIGMOID && neg_ff) ? -16'(r) : 16'(r);
      end
   end

endmodule

`default_nettype wire

/* rtl/lstm_cell_forward_pointwise.sv */
// ----------------------------------------------------------------------------
// lstm_cell_forward_pointwise
// Pointwise LSTM cell forward step in signed fixed point, with bias store.
// ----------------------------------------------------------------------------
// One item per cycle, unless rsp_stall holds the pipe, through nine stages;
// a compute response is valid once its item reaches the response register.
// A load item writes the summed biases of one feature into the bias RAM at
// its transfer edge and yields no response; a compute item reads the RAM at
// its transfer edge into the read register, so a compute that follows a
// load of the same feature sees the new entry with no forwarding needed.
// Each pipeline stage holds its item until the next stage is free, so
// bubbles are squeezed out while the response register waits on rsp_stall.
// Stages: 1 preactivation sums + RAM read, 2-3 gate activations, 4 products,
// 5 new cell, 6-7 tanh of cell, 8 output-gate product, 9 response register.
// Bias entries never written must not be read while bias is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module lstm_cell_forward_pointwise #(
   parameter int MAX_FEATURES = 1024,
   parameter int FRAC_BITS    = 12
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_write_enable,
   input  wire               csr_write_data,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_operation,
   input  wire        [9:0]  req_feature_index,
   input  wire signed [15:0] req_pre_in_i,
   input  wire signed [15:0] req_pre_in_f,
   input  wire signed [15:0] req_pre_in_c,
   input  wire signed [15:0] req_pre_in_o,
   input  wire signed [15:0] req_pre_hid_i,
   input  wire signed [15:0] req_pre_hid_f,
   input  wire signed [15:0] req_pre_hid_c,
   input  wire signed [15:0] req_pre_hid_o,
   input  wire signed [15:0] req_prev_cell,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic signed [15:0] rsp_hidden_out,
   output logic signed [15:0] rsp_cell_out,
   output logic       [12:0] rsp_act_input_gate,
   output logic       [12:0] rsp_act_forget_gate,
   output logic signed [13:0] rsp_act_candidate,
   output logic       [12:0] rsp_act_output_gate
);

   localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NS = 9;
   localparam logic signed [33:0] RND = 34'sd1 <<< (FRAC_BITS - 1);

   // configuration
   logic bias_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         bias_enable_ff <= csr_write_data;
      end
   end

   // pipeline occupancy, stage k advances when it is empty or k+1 advances
   logic [NS:1]   vld_ff;
   logic [NS+1:1] adv;

   always_comb begin
      adv[NS+1] = !rsp_stall;
      for (int s = NS; s >= 1; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end

   assign req_stall = !adv[1];

   logic req_xfer, in_range, cmp_xfer, ld_xfer;
   assign req_xfer = req_valid && !req_stall;
   assign in_range = 32'(req_feature_index) < MAX_FEATURES;
   assign cmp_xfer = req_xfer && (req_operation == lcfp_pkg::OP_COMPUTE);
   assign ld_xfer  = req_xfer && (req_operation == lcfp_pkg::OP_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) vld_ff[1] <= cmp_xfer;
         for (int s = 2; s <= NS; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // bias store
   lcfp_pkg::bias_entry_type wr_entry, rd_entry;

   always_comb begin
      wr_entry.gi = lcfp_pkg::sat16(34'(req_pre_in_i) + 34'(req_pre_hid_i));
      wr_entry.gf = lcfp_pkg::sat16(34'(req_pre_in_f) + 34'(req_pre_hid_f));
      wr_entry.gc = lcfp_pkg::sat16(34'(req_pre_in_c) + 34'(req_pre_hid_c));
      wr_entry.go = lcfp_pkg::sat16(34'(req_pre_in_o) + 34'(req_pre_hid_o));
   end

   lcfp_bias_mem #(.DEPTH(MAX_FEATURES), .AW(AW)) u_bias_mem (
      .clock   (clock),
      .wr_en   (ld_xfer && in_range),
      .wr_addr (AW'(req_feature_index)),
      .wr_data (wr_entry),
      .rd_en   (cmp_xfer && in_range),
      .rd_addr (AW'(req_feature_index)),
      .rd_data (rd_entry)
   );

   // stage 1: unbiased sums
   logic signed [16:0] s1_sum_i_ff, s1_sum_f_ff, s1_sum_c_ff, s1_sum_o_ff;
   logic signed [15:0] s1_prev_ff;
   logic               s1_use_bias_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_sum_i_ff    <= 17'(req_pre_in_i) + 17'(req_pre_hid_i);
         s1_sum_f_ff    <= 17'(req_pre_in_f) + 17'(req_pre_hid_f);
         s1_sum_c_ff    <= 17'(req_pre_in_c) + 17'(req_pre_hid_c);
         s1_sum_o_ff    <= 17'(req_pre_in_o) + 17'(req_pre_hid_o);
         s1_prev_ff     <= req_prev_cell;
         s1_use_bias_ff <= bias_enable_ff && in_range;
      end
   end

   // gate preactivations plus bias when enabled and in range, saturated
   lcfp_pkg::bias_entry_type bias_sel;
   logic signed [15:0] gate_i, gate_f, gate_c, gate_o;

   always_comb begin
      bias_sel = s1_use_bias_ff ? rd_entry : '0;
      gate_i = lcfp_pkg::sat16(34'(s1_sum_i_ff) + 34'(bias_sel.gi));
      gate_f = lcfp_pkg::sat16(34'(s1_sum_f_ff) + 34'(bias_sel.gf));
      gate_c = lcfp_pkg::sat16(34'(s1_sum_c_ff) + 34'(bias_sel.gc));
      gate_o = lcfp_pkg::sat16(34'(s1_sum_o_ff) + 34'(bias_sel.go));
   end

   // stages 2-3: activations
   logic signed [15:0] act_i, act_f, act_c, act_o;

   lcfp_act #(.FRAC_BITS(FRAC_BITS), .SIGMOID(1'b1)) u_act_i (
      .clock(clock), .en_a(adv[2]), .en_b(adv[3]), .x(gate_i), .y(act_i));
   lcfp_act #(.FRAC_BITS(FRAC_BITS), .SIGMOID(1'b1)) u_act_f (
      .clock(clock), .en_a(adv[2]), .en_b(adv[3]), .x(gate_f), .y(act_f));
   lcfp_act #(.FRAC_BITS(FRAC_BITS), .SIGMOID(1'b0)) u_act_c (
      .clock(clock), .en_a(adv[2]), .en_b(adv[3]), .x(gate_c), .y(act_c));
   lcfp_act #(.FRAC_BITS(FRAC_BITS), .SIGMOID(1'b1)) u_act_o (
      .clock(clock), .en_a(adv[2]), .en_b(adv[3]), .x(gate_o), .y(act_o));

   logic signed [15:0] s2_prev_ff, s3_prev_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) s2_prev_ff <= s1_prev_ff;
      if (adv[3]) s3_prev_ff <= s2_prev_ff;
   end

   // stage 4: f*c and i*g
   logic signed [31:0] s4_fc_ff, s4_ig_ff;
   logic signed [15:0] s4_ai_ff, s4_af_ff, s4_ac_ff, s4_ao_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_fc_ff <= act_f * s3_prev_ff;
         s4_ig_ff <= act_i * act_c;
         s4_ai_ff <= act_i;
         s4_af_ff <= act_f;
         s4_ac_ff <= act_c;
         s4_ao_ff <= act_o;
      end
   end

   // stage 5: new cell, rounded half up and saturated
   logic signed [33:0] cell_sum;
   logic signed [15:0] s5_cell_ff;
   logic signed [15:0] s5_ai_ff, s5_af_ff, s5_ac_ff, s5_ao_ff;

   assign cell_sum = (34'(s4_fc_ff) + 34'(s4_ig_ff) + RND) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_cell_ff <= lcfp_pkg::sat16(cell_sum);
         s5_ai_ff   <= s4_ai_ff;
         s5_af_ff   <= s4_af_ff;
         s5_ac_ff   <= s4_ac_ff;
         s5_ao_ff   <= s4_ao_ff;
      end
   end

   // stages 6-7: tanh of the new cell
   logic signed [15:0] tanh_cell;

   lcfp_act #(.FRAC_BITS(FRAC_BITS), .SIGMOID(1'b0)) u_act_cell (
      .clock(clock), .en_a(adv[6]), .en_b(adv[7]), .x(s5_cell_ff), .y(tanh_cell));

   logic signed [15:0] s6_cell_ff, s7_cell_ff;
   logic signed [15:0] s6_ai_ff, s6_af_ff, s6_ac_ff, s6_ao_ff;
   logic signed [15:0] s7_ai_ff, s7_af_ff, s7_ac_ff, s7_ao_ff;

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_cell_ff <= s5_cell_ff;
         s6_ai_ff   <= s5_ai_ff;
         s6_af_ff   <= s5_af_ff;
         s6_ac_ff   <= s5_ac_ff;
         s6_ao_ff   <= s5_ao_ff;
      end
      if (adv[7]) begin
         s7_cell_ff <= s6_cell_ff;
         s7_ai_ff   <= s6_ai_ff;
         s7_af_ff   <= s6_af_ff;
         s7_ac_ff   <= s6_ac_ff;
         s7_ao_ff   <= s6_ao_ff;
      end
   end

   // stage 8: o*tanh(cell)
   logic signed [31:0] s8_oh_ff;
   logic signed [15:0] s8_cell_ff;
   logic signed [15:0] s8_ai_ff, s8_af_ff, s8_ac_ff, s8_ao_ff;

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_oh_ff   <= s7_ao_ff * tanh_cell;
         s8_cell_ff <= s7_cell_ff;
         s8_ai_ff   <= s7_ai_ff;
         s8_af_ff   <= s7_af_ff;
         s8_ac_ff   <= s7_ac_ff;
         s8_ao_ff   <= s7_ao_ff;
      end
   end

   // stage 9: response register
   logic signed [33:0] hid_sum;
   assign hid_sum = (34'(s8_oh_ff) + RND) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         rsp_hidden_out      <= lcfp_pkg::sat16(hid_sum);
         rsp_cell_out        <= s8_cell_ff;
         rsp_act_input_gate  <= s8_ai_ff[12:0];
         rsp_act_forget_gate <= s8_af_ff[12:0];
         rsp_act_candidate   <= s8_ac_ff[13:0];
         rsp_act_output_gate <= s8_ao_ff[12:0];
      end
   end

   assign rsp_valid = vld_ff[NS];

   // a load transfer never enters the pipeline
   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      ld_xfer |=> !vld_ff[1])
      else $error("load item entered compute pipeline");

   // nothing valid right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input- and output-gate sigmoid outputs stay within one
   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && FRAC_BITS <= 12) |->
         (rsp_act_input_gate <= 13'(1 << FRAC_BITS)) &&
         (rsp_act_output_gate <= 13'(1 << FRAC_BITS)))
      else $error("gate activation above one");

endmodule

`default_nettype wire

/* verif/tb_lstm_cell_forward_pointwise.sv */
// ----------------------------------------------------------------------------
// tb_lstm_cell_forward_pointwise
// Self-checking bench for the pointwise LSTM cell: a directed table of bias
// loads and computes, then random traffic, scored against an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lstm_cell_forward_pointwise;

   localparam int FRAC = 12;
   localparam int NFEAT = 1024;
   localparam int LATENCY = 9;

   // one request transfer
   typedef struct {
      logic              op;
      logic [9:0]        fidx;
      logic signed [15:0] pin [4];
      logic signed [15:0] phid [4];
      logic signed [15:0] cprev;
   } cell_req_type;

   // one response transfer
   typedef struct {
      logic signed [15:0] hid;
      logic signed [15:0] cval;
      logic [12:0]        ai;
      logic [12:0]        af;
      logic signed [13:0] ag;
      logic [12:0]        ao;
   } cell_rsp_type;

   // directed row: request, plus an optional typed-in answer
   typedef struct {
      cell_req_type req;
      logic         has_known;
      cell_rsp_type known;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = 1'b0;
   logic [9:0] req_feature_index = '0;
   logic signed [15:0] req_pre_in_i = '0, req_pre_in_f = '0;
   logic signed [15:0] req_pre_in_c = '0, req_pre_in_o = '0;
   logic signed [15:0] req_pre_hid_i = '0, req_pre_hid_f = '0;
   logic signed [15:0] req_pre_hid_c = '0, req_pre_hid_o = '0;
   logic signed [15:0] req_prev_cell = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_hidden_out, rsp_cell_out;
   logic [12:0] rsp_act_input_gate, rsp_act_forget_gate, rsp_act_output_gate;
   logic signed [13:0] rsp_act_candidate;

   lstm_cell_forward_pointwise u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_feature_index   (req_feature_index),
      .req_pre_in_i        (req_pre_in_i),
      .req_pre_in_f        (req_pre_in_f),
      .req_pre_in_c        (req_pre_in_c),
      .req_pre_in_o        (req_pre_in_o),
      .req_pre_hid_i       (req_pre_hid_i),
      .req_pre_hid_f       (req_pre_hid_f),
      .req_pre_hid_c       (req_pre_hid_c),
      .req_pre_hid_o       (req_pre_hid_o),
      .req_prev_cell       (req_prev_cell),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_hidden_out      (rsp_hidden_out),
      .rsp_cell_out        (rsp_cell_out),
      .rsp_act_input_gate  (rsp_act_input_gate),
      .rsp_act_forget_gate (rsp_act_forget_gate),
      .rsp_act_candidate   (rsp_act_candidate),
      .rsp_act_output_gate (rsp_act_output_gate)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Cell model: own copy of the bias store and the enable bit.
   // ---------------------------------------------------------------------
   logic signed [15:0] gate_bias [NFEAT][4];
   bit                 bias_written [NFEAT];
   logic               bias_on = 1'b0;
   cell_rsp_type       pending_cells [$];

   // tanh(k/4) points in Q0.16
   int unsigned tanh_pts [33] = '{
      0, 16051, 30285, 41625, 49912, 55593, 59320, 61694,
      63179, 64096, 64659, 65003, 65212, 65339, 65417, 65464,
      65492, 65509, 65520, 65526, 65530, 65532, 65534, 65535,
      65535, 65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536};

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // interpolated tanh magnitude, s fraction bits per table step
   function automatic longint interp_tanh(longint mag, int s);
      longint k, fr, d;
      k = mag >> s;
      if (k >= 32) return tanh_pts[32];
      fr = mag & ((longint'(1) << s) - 1);
      d = tanh_pts[k + 1] - tanh_pts[k];
      return tanh_pts[k] + ((d * fr) >> s);
   endfunction

   function automatic longint tanh_q(longint x);
      longint r;
      r = (interp_tanh(x < 0 ? -x : x, FRAC - 2) + (1 << (15 - FRAC))) >> (16 - FRAC);
      return x < 0 ? -r : r;
   endfunction

   function automatic longint sigm_q(longint x);
      longint t, s;
      t = interp_tanh(x < 0 ? -x : x, FRAC - 1);
      s = x < 0 ? 65536 - t : 65536 + t;
      return (s + (1 << (16 - FRAC))) >> (17 - FRAC);
   endfunction

   // half-up rounding of a 2*FRAC product; >>> floors on signed longint
   function automatic longint round_q(longint v);
      return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   // returns 1 when the request yields a cell result
   function automatic bit predict_cell(cell_req_type r, output cell_rsp_type o);
      longint g [4], a [4], b, c, h;
      if (r.op == lcfp_pkg::OP_LOAD) begin
         for (int k = 0; k < 4; k++)
            gate_bias[r.fidx][k] = 16'(clamp16(longint'(r.pin[k]) + r.phid[k]));
         bias_written[r.fidx] = 1'b1;
         return 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
         b = bias_on ? longint'(gate_bias[r.fidx][k]) : 0;
         g[k] = clamp16(longint'(r.pin[k]) + r.phid[k] + b);
      end
      a[0] = sigm_q(g[0]);
      a[1] = sigm_q(g[1]);
      a[2] = tanh_q(g[2]);
      a[3] = sigm_q(g[3]);
      c = clamp16(round_q(a[1] * r.cprev + a[0] * a[2]));
      h = clamp16(round_q(a[3] * tanh_q(c)));
      o.hid  = 16'(h);
      o.cval = 16'(c);
      o.ai   = 13'(a[0]);
      o.af   = 13'(a[1]);
      o.ag   = 14'(a[2]);
      o.ao   = 13'(a[3]);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall, compare against oldest expectation.
   // ---------------------------------------------------------------------
   int  mismatches = 0;
   int  cells_seen = 0;
   bit  calm = 1'b0;   // no-idle stretch on both sides

   always @(posedge clock) begin
      cell_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            cells_seen++;
            if (pending_cells.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected cell transfer", $realtime);
            end else begin
               e = pending_cells.pop_front();
               if (e.hid !== rsp_hidden_out || e.cval !== rsp_cell_out
                   || e.ai !== rsp_act_input_gate || e.af !== rsp_act_forget_gate
                   || e.ag !== rsp_act_candidate || e.ao !== rsp_act_output_gate) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch exp h=%0d c=%0d i=%0d f=%0d g=%0d o=%0d",
                        $realtime, e.hid, e.cval, e.ai, e.af, e.ag, e.ao);
                     $display("%0t:          got h=%0d c=%0d i=%0d f=%0d g=%0d o=%0d",
                        $realtime, rsp_hidden_out, rsp_cell_out, rsp_act_input_gate,
                        rsp_act_forget_gate, rsp_act_candidate, rsp_act_output_gate);
                  end
               end
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   int sent_items = 0;
   int loads_sent = 0;

   // hold one request until transferred, then drop valid unless chained
   task automatic send_req(cell_req_type r);
      cell_rsp_type e;
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= r.op;
      req_feature_index <= r.fidx;
      req_pre_in_i  <= r.pin[0];  req_pre_in_f  <= r.pin[1];
      req_pre_in_c  <= r.pin[2];  req_pre_in_o  <= r.pin[3];
      req_pre_hid_i <= r.phid[0]; req_pre_hid_f <= r.phid[1];
      req_pre_hid_c <= r.phid[2]; req_pre_hid_o <= r.phid[3];
      req_prev_cell <= r.cprev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      if (predict_cell(r, e)) pending_cells.push_back(e);
      if (r.op == lcfp_pkg::OP_LOAD) loads_sent++;
      sent_items++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every cell result is back, then let the pipe empty
   task automatic drain();
      go_quiet();
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_bias_enable(logic v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      bias_on = v;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cell_req_type make_req(logic op, logic [9:0] fi,
                                             logic signed [15:0] v,
                                             logic signed [15:0] c);
      cell_req_type r;
      r.op = op; r.fidx = fi; r.cprev = c;
      for (int k = 0; k < 4; k++) begin
         r.pin[k] = v; r.phid[k] = v;
      end
      return r;
   endfunction

   function automatic cell_req_type rand_req(bit op_load);
      cell_req_type r;
      int q;
      r.op = op_load ? lcfp_pkg::OP_LOAD : lcfp_pkg::OP_COMPUTE;
      // computes with bias on only touch written entries
      do r.fidx = 10'($urandom_range(1023));
      while (!op_load && bias_on && !bias_written[r.fidx]);
      for (int k = 0; k < 4; k++) begin
         // mostly moderate values so activations sit in their live range
         q = $urandom_range(9);
         r.pin[k]  = q < 2 ? 16'($urandom) : 16'($signed($urandom_range(24000)) - 12000);
         r.phid[k] = q == 0 ? 16'($urandom) : 16'($signed($urandom_range(8000)) - 4000);
      end
      r.cprev = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : 16'($signed($urandom_range(40000)) - 20000);
      return r;
   endfunction

   dir_row_type dir_rows [$];

   function automatic dir_row_type row(cell_req_type r, bit known,
                                       int h, int c, int i, int f, int g, int o);
      dir_row_type d;
      d.req = r; d.has_known = known;
      d.known.hid = 16'(h); d.known.cval = 16'(c);
      d.known.ai = 13'(i); d.known.af = 13'(f); d.known.ag = 14'(g); d.known.ao = 13'(o);
      return d;
   endfunction

   initial begin
      cell_rsp_type e;
      cell_req_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed table (bias off after reset) ---
      // zero gates: sigmoid 0.5, tanh 0, cell = 0.5*c
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd0, 16'sd0, 16'sd0), 1,
                             0, 0, 2048, 2048, 0, 2048));
      // all gates saturated high: sigmoid tops out one lsb below one, tanh one
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd1023, 16'sh7fff,
                                      16'sd4096), 1,
                             3948, 8190, 4095, 4095, 4096, 4095));
      // all gates saturated low: sigmoids bottom out at one lsb, tanh -one
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd5, 16'sh8000,
                                      16'sh8000), 1,
                             0, -9, 1, 1, -4096, 1));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd7, 16'sh7fff, 16'sh7fff), 0,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd9, 16'sh8000, 16'sh7fff), 0,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd2, 16'sd1, 16'sh8000), 0,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd3, -16'sd1, 16'sd12345), 0,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd4, 16'sd3000, -16'sd3000), 0,
                             0, 0, 0, 0, 0, 0));
      // loads: saturating sums, edge indexes, prev cell ignored
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_LOAD, 10'd0, 16'sh7fff, 16'sh7fff), 0,
                             0, 0, 0, 0, 0, 0));
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_LOAD, 10'd1023, 16'sh8000, 16'sh5555), 0,
                             0, 0, 0, 0, 0, 0));
      r = make_req(lcfp_pkg::OP_LOAD, 10'd512, 16'sd1000, -16'sd300);
      r.pin[1] = 16'sh8000; r.phid[1] = 16'sh8000; r.pin[2] = 16'sh2aaa;
      dir_rows.push_back(row(r, 0, 0, 0, 0, 0, 0, 0));
      // load then compute on the same feature, bias still off
      dir_rows.push_back(row(make_req(lcfp_pkg::OP_COMPUTE, 10'd512, 16'sd100, 16'sd200), 0,
                             0, 0, 0, 0, 0, 0));
      foreach (dir_rows[n]) begin
         send_req(dir_rows[n].req);
         if (dir_rows[n].has_known) begin
            // swap the computed expectation for the typed-in one
            e = pending_cells.pop_back();
            pending_cells.push_back(dir_rows[n].known);
         end
      end
      drain();

      // bias on: hit written entries, then reload one and use it at once
      write_bias_enable(1'b1);
      send_req(make_req(lcfp_pkg::OP_COMPUTE, 10'd0, 16'sd0, 16'sd100));
      send_req(make_req(lcfp_pkg::OP_COMPUTE, 10'd1023, 16'sd500, -16'sd100));
      send_req(make_req(lcfp_pkg::OP_COMPUTE, 10'd512, -16'sd9000, 16'sh7fff));
      send_req(make_req(lcfp_pkg::OP_LOAD, 10'd512, -16'sd20000, -16'sd20000));
      send_req(make_req(lcfp_pkg::OP_COMPUTE, 10'd512, 16'sh7fff, 16'sd50));
      go_quiet();   // sender drops valid; drain waits for every result
      drain();

      // --- random phases across both enable settings ---
      for (int ph = 0; ph < 6; ph++) begin
         write_bias_enable(ph[0]);
         calm = (ph == 3);
         for (int n = 0; n < 150; n++)
            send_req(rand_req($urandom_range(99) < 25));
         drain();
      end
      calm = 1'b0;

      $display("Sent %0d transfers (%0d bias loads), checked %0d cell results.",
               sent_items, loads_sent, cells_seen);
      $display("Bias enable toggled both ways; gate inputs spanned full 16-bit range.");
      if (mismatches == 0 && pending_cells.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
